>>> hw/rtl/texture_bilinear_sampler_defines.svh
// ----------------------------------------------------------------------------
// Texture bilinear sampler: assertion macros
// Concurrent checks on the sampler pipeline, compiled out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_BILINEAR_SAMPLER_DEFINES_SVH
`define TEXTURE_BILINEAR_SAMPLER_DEFINES_SVH

`ifndef SYNTH
// Check that the consequent holds in the same cycle as the antecedent
`define TBS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbs: implication check failed");
// Check a condition at every clock edge out of reset
`define TBS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tbs: invariant check failed");
`else
`define TBS_ASSERT_IMPL(lbl, ante, cons)
`define TBS_ASSERT_ALWAYS(lbl, cond)
`endif

`endif

>>> hw/rtl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// Texture bilinear sampler package
// Sizes, payload structs, register indexes and the per-axis tap arithmetic.
// ----------------------------------------------------------------------------
package tbs_pkg;

  // Texture store geometry and filter precision
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int WEIGHT_BITS = 8;

  // Coordinate and size widths
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int SZW     = 9;
  localparam int TW      = SZW - 1;
  localparam int CW      = 16;
  localparam int PW      = CW + SZW;
  localparam int HALF    = 1 << (CW - 1);

  // Banked store: four banks split by column and row parity
  localparam int NB         = 4;
  localparam int BANK_AW    = (XW - 1) + (YW - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int TEXEL_W    = 32;

  // Lerp widths
  localparam int WONE_W  = WEIGHT_BITS + 1;
  localparam int WONE    = 1 << WEIGHT_BITS;
  localparam int PROD1_W = 8 + WONE_W;
  localparam int LERP1_W = 8 + WEIGHT_BITS;
  localparam int PROD2_W = LERP1_W + WONE_W;
  localparam int LERP2_W = 8 + 2 * WEIGHT_BITS;
  localparam int RND     = 1 << (2 * WEIGHT_BITS - 1);

  // Item codes
  localparam logic FUNC_WRITE     = 1'b0;
  localparam logic FUNC_SAMPLE    = 1'b1;
  localparam logic FILT_NEAREST   = 1'b0;
  localparam logic FILT_BILINEAR  = 1'b1;

  // Register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_TEX_WIDTH   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_TEX_HEIGHT  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_FILTER_MODE = 2'd2;

  typedef struct packed {
    logic                func;
    logic [7:0]          texel_x;
    logic [7:0]          texel_y;
    logic [TEXEL_W-1:0]  texel_rgba;
    logic [CW-1:0]       u_coord;
    logic [CW-1:0]       v_coord;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_item_t;

  // Two taps and the weight of the far tap along one axis
  typedef struct packed {
    logic [TW-1:0]          lo;
    logic [TW-1:0]          hi;
    logic [WEIGHT_BITS-1:0] wt;
  } axis_t;

  // Parity of each tap, which picks the bank that holds it
  typedef struct packed {
    logic x0p;
    logic x1p;
    logic y0p;
    logic y1p;
  } tap_sel_t;

  // Map a size register value into 1..maxv
  function automatic logic [SZW-1:0] eff_size(logic [SZW-1:0] v, int maxv);
    logic [SZW-1:0] r;
    if (v == '0) begin
      r = SZW'(1);
    end else if (int'(v) > maxv) begin
      r = SZW'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Turn coord*size into clamped taps and a weight; nearest gives one tap
  function automatic axis_t axis_taps(logic [PW-1:0] prod, logic [SZW-1:0] size,
                                      logic bil);
    logic [PW-1:0]  pb;
    logic [SZW-1:0] ip;
    logic [SZW-1:0] lim;
    logic [SZW-1:0] dn;
    logic [SZW-1:0] lo9;
    logic [SZW-1:0] hi9;
    axis_t          r;
    lim = size - 1'b1;
    pb  = bil ? (prod + PW'(HALF)) : prod;
    ip  = pb[PW-1 -: SZW];
    hi9 = (ip > lim) ? lim : ip;
    dn  = ip - 1'b1;
    if (bil) begin
      lo9  = (ip == '0) ? '0 : ((dn > lim) ? lim : dn);
      r.wt = pb[CW-1 -: WEIGHT_BITS];
    end else begin
      lo9  = hi9;
      r.wt = '0;
    end
    r.lo = lo9[TW-1:0];
    r.hi = hi9[TW-1:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/tbs_ram.sv
// ----------------------------------------------------------------------------
// Texture bilinear sampler: single-port RAM
// One access per cycle, read data registered; a write also reads the old word.
// ----------------------------------------------------------------------------
module tbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable; always read the old word into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/texture_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// Texture bilinear sampler over a banked RGBA8 texture store
// Throughput: one item per cycle; start is held off only while busy is high.
// A sample's result strobes on out_valid for one cycle once it has passed the
// stage 1 to 5 registers and the output register; writes give nothing.
// Rate is set by the six-stage pipeline and four parity banks of one port each.
// Reset: synchronous, rst_n low; busy is high during reset and in the cycle after.
// ----------------------------------------------------------------------------
`include "texture_bilinear_sampler_defines.svh"

module texture_bilinear_sampler import tbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [SZW-1:0]    cfg_data
);

  logic                   busy_r;
  logic [SZW-1:0]         tex_w_r;
  logic [SZW-1:0]         tex_h_r;
  logic                   filt_r;
  logic                   in_acc;

  // Stage 1: products
  logic                   s1_smp_r;
  logic                   s1_wr_r;
  logic                   wr_ok;
  logic [XW-1:0]          s1_wx_r;
  logic [YW-1:0]          s1_wy_r;
  logic [TEXEL_W-1:0]     s1_wdata_r;
  logic [PW-1:0]          s1_pu_r;
  logic [PW-1:0]          s1_pv_r;

  // Stage 2: taps and bank addresses
  axis_t                  xa;
  axis_t                  ya;
  logic [BANK_AW-1:0]     addr_nxt [NB];
  logic [NB-1:0]          we_nxt;
  tap_sel_t               sel_nxt;
  logic                   s2_smp_r;
  logic [NB-1:0]          s2_we_r;
  logic [BANK_AW-1:0]     s2_addr_r [NB];
  logic [TEXEL_W-1:0]     s2_wdata_r;
  tap_sel_t               s2_sel_r;
  logic [WEIGHT_BITS-1:0] s2_s_r;
  logic [WEIGHT_BITS-1:0] s2_t_r;

  // Stage 3: bank read data
  logic [TEXEL_W-1:0]     ram_rdata [NB];
  logic                   s3_smp_r;
  tap_sel_t               s3_sel_r;
  logic [WEIGHT_BITS-1:0] s3_s_r;
  logic [WEIGHT_BITS-1:0] s3_t_r;

  // Stage 4: lerp in x
  logic [LERP1_W-1:0]     top_nxt [4];
  logic [LERP1_W-1:0]     bot_nxt [4];
  logic                   s4_smp_r;
  logic [WEIGHT_BITS-1:0] s4_t_r;
  logic [LERP1_W-1:0]     s4_top_r [4];
  logic [LERP1_W-1:0]     s4_bot_r [4];

  // Stage 5: lerp in y
  logic [LERP2_W-1:0]     sum_nxt [4];
  logic                   s5_smp_r;
  logic [LERP2_W-1:0]     s5_sum_r [4];

  // Stage 6: rounded result
  out_item_t              out_nxt;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  assign in_acc    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Hold off items while in reset and for the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Configuration registers; sizes are stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= SZW'(MAX_WIDTH);
      tex_h_r <= SZW'(MAX_HEIGHT);
      filt_r  <= FILT_BILINEAR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEX_WIDTH:   tex_w_r <= eff_size(cfg_data, MAX_WIDTH);
        REG_TEX_HEIGHT:  tex_h_r <= eff_size(cfg_data, MAX_HEIGHT);
        REG_FILTER_MODE: filt_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Drop writes that fall outside the store
  assign wr_ok = (32'(in_item.texel_x) < 32'(MAX_WIDTH)) &&
                 (32'(in_item.texel_y) < 32'(MAX_HEIGHT));

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_smp_r <= 1'b0;
      s1_wr_r  <= 1'b0;
    end else begin
      s1_smp_r <= in_acc && (in_item.func == FUNC_SAMPLE);
      s1_wr_r  <= in_acc && (in_item.func == FUNC_WRITE) && wr_ok;
    end
  end

  // Stage 1 payload: scale coordinates by the texture size
  always_ff @(posedge clk) begin
    s1_wx_r    <= XW'(in_item.texel_x);
    s1_wy_r    <= YW'(in_item.texel_y);
    s1_wdata_r <= in_item.texel_rgba;
    s1_pu_r    <= PW'(in_item.u_coord) * PW'(tex_w_r);
    s1_pv_r    <= PW'(in_item.v_coord) * PW'(tex_h_r);
  end

  // Clamp taps and route each tap to its parity bank
  assign xa = axis_taps(s1_pu_r, tex_w_r, filt_r);
  assign ya = axis_taps(s1_pv_r, tex_h_r, filt_r);

  always_comb begin
    logic [XW-1:0] colx;
    logic [YW-1:0] rowy;
    sel_nxt.x0p = xa.lo[0];
    sel_nxt.x1p = xa.hi[0];
    sel_nxt.y0p = ya.lo[0];
    sel_nxt.y1p = ya.hi[0];
    for (int b = 0; b < NB; b++) begin
      colx = (xa.lo[0] == b[0]) ? xa.lo[XW-1:0] : xa.hi[XW-1:0];
      rowy = (ya.lo[0] == b[1]) ? ya.lo[YW-1:0] : ya.hi[YW-1:0];
      if (s1_wr_r) begin
        addr_nxt[b] = {s1_wy_r[YW-1:1], s1_wx_r[XW-1:1]};
      end else begin
        addr_nxt[b] = {rowy[YW-1:1], colx[XW-1:1]};
      end
      we_nxt[b] = s1_wr_r && (2'(b) == {s1_wy_r[0], s1_wx_r[0]});
    end
  end

  // Stage 2 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_smp_r <= 1'b0;
      s2_we_r  <= '0;
    end else begin
      s2_smp_r <= s1_smp_r;
      s2_we_r  <= we_nxt;
    end
  end

  // Stage 2 payload
  always_ff @(posedge clk) begin
    s2_addr_r  <= addr_nxt;
    s2_wdata_r <= s1_wdata_r;
    s2_sel_r   <= sel_nxt;
    s2_s_r     <= xa.wt;
    s2_t_r     <= ya.wt;
  end

  // Texture store: one bank per column and row parity
  for (genvar g = 0; g < NB; g++) begin : g_bank
    tbs_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (s2_we_r[g]),
      .addr  (s2_addr_r[g]),
      .wdata (s2_wdata_r),
      .rdata (ram_rdata[g])
    );
  end

  // Stage 3 sideband travels alongside the bank read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_smp_r <= 1'b0;
    end else begin
      s3_smp_r <= s2_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_sel_r <= s2_sel_r;
    s3_s_r   <= s2_s_r;
    s3_t_r   <= s2_t_r;
  end

  // Pick the four taps and lerp each channel in x
  always_comb begin
    logic [7:0]         a;
    logic [7:0]         b;
    logic [7:0]         c;
    logic [7:0]         d;
    logic [WONE_W-1:0]  sc;
    logic [PROD1_W-1:0] pa;
    logic [PROD1_W-1:0] pb;
    logic [PROD1_W-1:0] pc;
    logic [PROD1_W-1:0] pd;
    sc = WONE_W'(WONE) - WONE_W'(s3_s_r);
    for (int ch = 0; ch < 4; ch++) begin
      a  = ram_rdata[{s3_sel_r.y0p, s3_sel_r.x0p}][8*ch +: 8];
      b  = ram_rdata[{s3_sel_r.y0p, s3_sel_r.x1p}][8*ch +: 8];
      c  = ram_rdata[{s3_sel_r.y1p, s3_sel_r.x0p}][8*ch +: 8];
      d  = ram_rdata[{s3_sel_r.y1p, s3_sel_r.x1p}][8*ch +: 8];
      pa = PROD1_W'(a) * PROD1_W'(sc);
      pb = PROD1_W'(b) * PROD1_W'(s3_s_r);
      pc = PROD1_W'(c) * PROD1_W'(sc);
      pd = PROD1_W'(d) * PROD1_W'(s3_s_r);
      top_nxt[ch] = LERP1_W'(pa + pb);
      bot_nxt[ch] = LERP1_W'(pc + pd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_smp_r <= 1'b0;
    end else begin
      s4_smp_r <= s3_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_t_r   <= s3_t_r;
    s4_top_r <= top_nxt;
    s4_bot_r <= bot_nxt;
  end

  // Lerp each channel in y
  always_comb begin
    logic [WONE_W-1:0]  tc;
    logic [PROD2_W-1:0] qa;
    logic [PROD2_W-1:0] qb;
    tc = WONE_W'(WONE) - WONE_W'(s4_t_r);
    for (int ch = 0; ch < 4; ch++) begin
      qa = PROD2_W'(s4_top_r[ch]) * PROD2_W'(tc);
      qb = PROD2_W'(s4_bot_r[ch]) * PROD2_W'(s4_t_r);
      sum_nxt[ch] = LERP2_W'(qa + qb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_smp_r <= 1'b0;
    end else begin
      s5_smp_r <= s4_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_sum_r <= sum_nxt;
  end

  // Round half up to eight bits and saturate
  always_comb begin
    logic [LERP2_W:0] rnd;
    logic [8:0]       r;
    logic [7:0]       chan [4];
    for (int ch = 0; ch < 4; ch++) begin
      rnd = {1'b0, s5_sum_r[ch]} + (LERP2_W + 1)'(RND);
      r   = rnd[LERP2_W -: 9];
      chan[ch] = r[8] ? 8'hFF : r[7:0];
    end
    out_nxt.red   = chan[0];
    out_nxt.green = chan[1];
    out_nxt.blue  = chan[2];
    out_nxt.alpha = chan[3];
  end

  // Output register: strobe for one cycle per sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s5_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // At most one bank is written per cycle
  `TBS_ASSERT_ALWAYS(a_one_bank_write, $onehot0(s2_we_r))
  // A sample in flight never writes the store
  `TBS_ASSERT_IMPL(a_sample_no_write, s2_smp_r, s2_we_r == '0)
  // Column taps are adjacent or equal and stay inside the texture
  `TBS_ASSERT_IMPL(a_x_taps, s1_smp_r, ((xa.hi == xa.lo) || (xa.hi == xa.lo + 1'b1)) && (SZW'(xa.hi) < tex_w_r))
  // Row taps are adjacent or equal and stay inside the texture
  `TBS_ASSERT_IMPL(a_y_taps, s1_smp_r, ((ya.hi == ya.lo) || (ya.hi == ya.lo + 1'b1)) && (SZW'(ya.hi) < tex_h_r))

endmodule
